FILE: src/imfs_pkg.sv
`default_nettype none

package imfs_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    // Configuration register indexes.
    localparam logic REG_SONG_SIZE   = 1'b0;
    localparam logic REG_LOOP_ENABLE = 1'b1;

    // Song format constants.
    localparam logic [15:0] SIZE_TRIM_MASK  = 16'hFFFC;
    localparam logic [15:0] CHUNK_SIZE_MASK = 16'hFCFF;
    localparam logic [15:0] BYTES_PER_STEP  = 16'd4;
    localparam int          DELAY_SHIFT     = 7;

    // Enables sent to the song memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctrl_t;

    // Byte count of a chunked song, taken from its first word.
    function automatic logic [15:0] chunk_bytes(input logic [15:0] word0);
        logic [15:0] masked;
        masked = word0 & CHUNK_SIZE_MASK;
        return {masked[7:0], masked[15:8]};
    endfunction

endpackage

`default_nettype wire

FILE: src/imfs_song_mem.sv
`default_nettype none

module imfs_song_mem
    import imfs_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire mem_ctrl_t     ctrl,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output logic      [15:0]   rd_data_a,
    output logic      [15:0]   rd_data_b
);

    logic [15:0] mem [DEPTH];

    // One write port and two read ports, read data registered.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: src/imf_music_sequencer.sv
// Accepts one request per cycle while the result path has room.
// A tick that reads a word pair returns its OPL word through the song memory's
// read register and then the output register; the pair comes from both read ports of the song memory.
// The wait count of such a tick, unless it reads the last pair, is forwarded from the read data in the cycle after.
// Reset clears playback state, sets loop enable and leaves the song memory as is.
`default_nettype none

module imf_music_sequencer
    import imfs_pkg::*;
#(
    parameter int SONG_WORDS = 16384
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [13:0] word_addr,
    input  wire logic [15:0] word_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      opl_word
);

    localparam int AW = $clog2(SONG_WORDS);
    localparam logic [AW-1:0] LAST_INDEX = AW'(SONG_WORDS - 1);

    logic [15:0]   size_cfg_reg;
    logic          loop_reg;
    logic [15:0]   start_size_reg, start_size_next;
    logic [AW-1:0] ri_reg, ri_next;
    logic [15:0]   bytes_reg, bytes_next;
    logic [15:0]   wait_reg, wait_next;
    logic          chunked_reg, chunked_next;
    logic          playing_reg, playing_next;
    logic [15:0]   w0_reg, w0_next;
    logic [15:0]   w1_reg, w1_next;
    logic          pend_reg, pend_next;
    logic          res_valid_reg, res_valid_next;
    logic          out_valid_reg;
    logic [15:0]   opl_word_reg;

    logic          accept;
    logic          move;
    logic [15:0]   wait_cur;
    logic [AW-1:0] ri_plus1, ri_plus2;
    logic [15:0]   bytes_after;
    logic [AW-1:0] rw_ri;
    logic [15:0]   rw_bytes;
    logic [15:0]   trim_size;
    logic          start_chunked;
    logic          addr_ok;
    mem_ctrl_t     mem_ctrl;
    logic [15:0]   rd_data_a, rd_data_b;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= '0;
            loop_reg     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SONG_SIZE:   size_cfg_reg <= cfg_data;
                REG_LOOP_ENABLE: loop_reg     <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // The result in the read register moves on when the output register frees.
    assign move     = res_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !res_valid_reg || move;
    assign accept   = in_valid && in_ready;

    // The wait count of a pair read last cycle comes straight from the read data.
    assign wait_cur = pend_reg ? 16'(rd_data_b >> DELAY_SHIFT) : wait_reg;

    // Read index steps, wrapping at the end of the memory.
    assign ri_plus1 = (ri_reg == LAST_INDEX) ? '0 : ri_reg + AW'(1);
    assign ri_plus2 = (ri_plus1 == LAST_INDEX) ? '0 : ri_plus1 + AW'(1);

    assign bytes_after = (bytes_reg >= BYTES_PER_STEP) ? bytes_reg - BYTES_PER_STEP : '0;

    // Rewind values for a loop, from the latched size and the current first word.
    assign rw_ri    = chunked_reg ? AW'(1) : '0;
    assign rw_bytes = chunked_reg ? chunk_bytes(w0_reg) : start_size_reg;

    assign trim_size     = size_cfg_reg & SIZE_TRIM_MASK;
    assign start_chunked = !(w0_reg == '0 && w1_reg == '0);
    assign addr_ok       = 32'(word_addr) < SONG_WORDS;

    // Request decode and playback state update.
    always_comb
    begin
        start_size_next = start_size_reg;
        ri_next         = ri_reg;
        bytes_next      = bytes_reg;
        wait_next       = wait_cur;
        chunked_next    = chunked_reg;
        playing_next    = playing_reg;
        w0_next         = w0_reg;
        w1_next         = w1_reg;
        pend_next       = 1'b0;
        mem_ctrl        = '0;

        if (accept)
        begin
            case (op)
                OP_WRITE:
                begin
                    if (addr_ok)
                    begin
                        mem_ctrl.wr_en = 1'b1;
                        if (word_addr == 14'd0)
                        begin
                            w0_next = word_data;
                        end
                        if (word_addr == 14'd1)
                        begin
                            w1_next = word_data;
                        end
                    end
                end
                OP_START:
                begin
                    start_size_next = trim_size;
                    wait_next       = '0;
                    chunked_next    = start_chunked;
                    ri_next         = start_chunked ? AW'(1) : '0;
                    bytes_next      = start_chunked ? chunk_bytes(w0_reg) : trim_size;
                    playing_next    = 1'b1;
                end
                OP_TICK:
                begin
                    if (playing_reg)
                    begin
                        if (bytes_reg != '0 && wait_cur == '0)
                        begin
                            // Read the word pair; the wait count follows next cycle.
                            mem_ctrl.rd_en = 1'b1;
                            if (bytes_after != '0)
                            begin
                                ri_next    = ri_plus2;
                                bytes_next = bytes_after;
                                pend_next  = 1'b1;
                            end
                            else
                            begin
                                wait_next = '0;
                                if (loop_reg)
                                begin
                                    ri_next    = rw_ri;
                                    bytes_next = rw_bytes;
                                end
                                else
                                begin
                                    ri_next      = ri_plus2;
                                    bytes_next   = '0;
                                    playing_next = 1'b0;
                                end
                            end
                        end
                        else if (bytes_reg == '0)
                        begin
                            // Song end reached with nothing to read.
                            wait_next = '0;
                            if (loop_reg)
                            begin
                                ri_next    = rw_ri;
                                bytes_next = rw_bytes;
                            end
                            else
                            begin
                                playing_next = 1'b0;
                            end
                        end
                        else
                        begin
                            wait_next = wait_cur - 16'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (mem_ctrl.rd_en)
        begin
            res_valid_next = 1'b1;
        end
        else if (move)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Playback state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_size_reg <= '0;
            ri_reg         <= '0;
            bytes_reg      <= '0;
            wait_reg       <= '0;
            chunked_reg    <= 1'b0;
            playing_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            start_size_reg <= start_size_next;
            ri_reg         <= ri_next;
            bytes_reg      <= bytes_next;
            wait_reg       <= wait_next;
            chunked_reg    <= chunked_next;
            playing_reg    <= playing_next;
            pend_reg       <= pend_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Copies of the first two song words for start and rewind.
    always_ff @(posedge clk)
    begin
        w0_reg <= w0_next;
        w1_reg <= w1_next;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            opl_word_reg <= rd_data_a;
        end
    end

    assign out_valid = out_valid_reg;
    assign opl_word  = opl_word_reg;

    imfs_song_mem #(
        .DEPTH (SONG_WORDS),
        .AW    (AW)
    ) u_song_mem (
        .clk       (clk),
        .ctrl      (mem_ctrl),
        .wr_addr   (AW'(word_addr)),
        .wr_data   (word_data),
        .rd_addr_a (ri_reg),
        .rd_addr_b (ri_plus1),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

endmodule

`default_nettype wire

FILE: src/imfs_checker.sv
`default_nettype none

module imfs_checker
    import imfs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  op,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] opl_word
);

    // A pending result stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(opl_word))
        else $error("result changed while stalled");

    // A fresh result must trace back to an accepted tick request that read it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && op == OP_TICK, 2))
        else $error("result without a tick request");

    // Requests are held back only while both result slots are full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled with room for results");

endmodule

bind imf_music_sequencer imfs_checker u_imfs_checker (.*);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import imfs_pkg::*;

    localparam int          SONG_DEPTH     = 16384;
    localparam int          FILL_WORDS     = 128;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [15:0] TRIM_MASK      = 16'hFFFC;
    localparam logic [15:0] CHUNK_MASK     = 16'hFCFF;
    localparam logic [15:0] STEP_BYTES     = 16'd4;
    localparam int          DELAY_UNIT_LOG = 7;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          MAX_GAP        = 40;
    localparam int          QUIET_LIMIT    = 2000;
    localparam int          PHASE_ITEMS    = 180;

    // One row of the directed script: either a register write or a request,
    // optionally with its result worked out by hand.
    typedef struct packed {
        logic        is_cfg;
        logic        reg_sel;
        logic [1:0]  op;
        logic [13:0] addr;
        logic [15:0] data;
        logic        fixed;
        logic        fixed_emit;
        logic [15:0] fixed_word;
    } script_row_t;

    localparam int SCRIPT_LEN = 21;

    script_row_t script [0:SCRIPT_LEN-1] = '{
        // Tick right after reset does nothing, nor does the unused op.
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_UNUSED, 14'h3FFF,  16'hFFFF, 1'b1, 1'b0, 16'h0000},
        // Plain song of 11 bytes, trimmed to 8, played once.
        '{1'b1, REG_LOOP_ENABLE, OP_WRITE, 14'd0, 16'h0000, 1'b0, 1'b0, 16'h0000},
        '{1'b1, REG_SONG_SIZE,   OP_WRITE, 14'd0, 16'h000B, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd0,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd1,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd2,     16'hFFFF, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd3,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_START,  14'd0,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b1, 16'h0000},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b1, 16'hFFFF},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b0, 16'h0000},
        // Chunked song whose masked header gives 4 bytes, looping.
        '{1'b1, REG_LOOP_ENABLE, OP_WRITE, 14'd0, 16'h0001, 1'b0, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd0,     16'h0700, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd1,     16'h1234, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_WRITE,  14'd2,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_START,  14'd0,     16'h0000, 1'b1, 1'b0, 16'h0000},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b1, 16'h1234},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b1, 16'h1234},
        '{1'b0, 1'b0, OP_TICK,   14'd0,     16'h0000, 1'b1, 1'b1, 16'h1234},
        '{1'b0, 1'b0, OP_WRITE,  14'h3FFF,  16'hFFFF, 1'b1, 1'b0, 16'h0000}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_WRITE;
    logic [13:0] word_addr = 14'd0;
    logic [15:0] word_data = 16'h0000;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [15:0] opl_word;

    // Sequencer state as the checker sees it.
    logic [15:0] song_words [SONG_DEPTH];
    logic [13:0] play_ptr = 14'd0;
    logic [15:0] bytes_remaining = 16'h0000;
    logic [15:0] delay_left = 16'h0000;
    logic        is_chunked = 1'b0;
    logic        song_running = 1'b0;
    logic [15:0] latched_size = 16'h0000;
    logic [15:0] size_reg = 16'h0000;
    logic        loop_reg = 1'b1;

    logic [15:0] pending_opl [$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          quiet_cycles = 0;
    int          sender_pct = 0;
    int          stall_pct = 0;

    imf_music_sequencer #(
        .SONG_WORDS(SONG_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .word_addr(word_addr),
        .word_data(word_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .opl_word(opl_word)
    );

    always #5 clk = ~clk;

    // Set up the read pointer and byte count for the start of the song.
    function automatic void rewind_song();
        logic [15:0] header;
        play_ptr = 14'd0;
        bytes_remaining = latched_size;
        if (is_chunked)
        begin
            header = song_words[0] & CHUNK_MASK;
            play_ptr = 14'd1;
            bytes_remaining = {header[7:0], header[15:8]};
        end
    endfunction

    // Advance the sequencer by one request and report the OPL word it emits.
    function automatic void play_step(input logic [1:0] req_op, input logic [13:0] addr,
                                      input logic [15:0] data, output bit emits,
                                      output logic [15:0] word);
        logic [15:0] delay_word;
        emits = 1'b0;
        word = 16'h0000;
        case (req_op)
            OP_WRITE:
            begin
                song_words[addr] = data;
            end
            OP_START:
            begin
                latched_size = size_reg & TRIM_MASK;
                delay_left = 16'h0000;
                is_chunked = (song_words[0] != 16'h0000) || (song_words[1] != 16'h0000);
                rewind_song();
                song_running = 1'b1;
            end
            OP_TICK:
            begin
                if (song_running)
                begin
                    if (bytes_remaining != 16'h0000 && delay_left == 16'h0000)
                    begin
                        word = song_words[play_ptr];
                        play_ptr = play_ptr + 14'd1;
                        delay_word = song_words[play_ptr];
                        play_ptr = play_ptr + 14'd1;
                        delay_left = (delay_word >> DELAY_UNIT_LOG) + 16'd1;
                        bytes_remaining = (bytes_remaining >= STEP_BYTES) ?
                                          bytes_remaining - STEP_BYTES : 16'h0000;
                        emits = 1'b1;
                    end
                    delay_left = delay_left - 16'd1;
                    // End of song: loop back or stop.
                    if (bytes_remaining == 16'h0000)
                    begin
                        if (loop_reg)
                            rewind_song();
                        else
                            song_running = 1'b0;
                        delay_left = 16'h0000;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Hold off new requests until every expected OPL word is back and the
    // pipeline has had time to finish any silent tick.
    task automatic await_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_opl.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write, only issued while the block is idle.
    task automatic set_register(input logic sel, input logic [15:0] value);
        await_drain();
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (sel == REG_SONG_SIZE)
            size_reg = value;
        else
            loop_reg = value[0];
    endtask

    // Send one request, then record the OPL word it should produce.
    task automatic put_req(input logic [1:0] req_op, input logic [13:0] addr,
                           input logic [15:0] data, input bit fixed, input bit fixed_emit,
                           input logic [15:0] fixed_word);
        int gap;
        bit emits;
        logic [15:0] word;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < sender_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= req_op;
        word_addr <= addr;
        word_data <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        play_step(req_op, addr, data, emits, word);
        if (fixed)
        begin
            emits = fixed_emit;
            word = fixed_word;
        end
        if (emits)
            pending_opl.push_back(word);
        if (req_op != OP_UNUSED)
            requests_sent++;
    endtask

    // Send a tick. The song is restarted first when the next word pair would
    // lie past the preloaded words, so every read hits a written word.
    task automatic put_tick();
        if (song_running && int'(play_ptr) > FILL_WORDS - 2)
            put_req(OP_START, 14'($urandom), 16'($urandom), 1'b0, 1'b0, 16'h0000);
        put_req(OP_TICK, 14'($urandom), 16'($urandom), 1'b0, 1'b0, 16'h0000);
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Compare each returned OPL word with the oldest expectation.
    always @(posedge clk)
    begin : check_opl
        logic [15:0] expected_word;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_opl.size() == 0)
            begin
                $error("opl_word: no result expected, actual %h", opl_word);
                mismatches++;
            end
            else
            begin
                expected_word = pending_opl.pop_front();
                if (opl_word !== expected_word)
                begin
                    $error("opl_word: expected %h, actual %h", expected_word, opl_word);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which no handshake completes.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int row;
        int ph;
        int k;
        int n;
        int phase_end;
        logic [15:0] head;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        for (row = 0; row < SCRIPT_LEN; row++)
        begin
            if (script[row].is_cfg)
                set_register(script[row].reg_sel, script[row].data);
            else
                put_req(script[row].op, script[row].addr, script[row].data,
                        script[row].fixed, script[row].fixed_emit, script[row].fixed_word);
        end

        // Preload the start of the song memory with short delays; ticks keep
        // their reads inside this region.
        for (k = 0; k < FILL_WORDS; k++)
            put_req(OP_WRITE, 14'(k), 16'($urandom_range(0, 255)), 1'b0, 1'b0, 16'h0000);

        // Random phases, each with its own register settings and idling.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: head = 16'hFFFF;
                1: head = 16'h0000;
                2: head = 16'h0003;
                3: head = 16'h0040;
                4: head = 16'($urandom);
                5: head = 16'h0082;
                6: head = 16'h0014;
                default: head = 16'h00FC;
            endcase
            set_register(REG_SONG_SIZE, head);
            set_register(REG_LOOP_ENABLE, {15'd0, ph[0] ^ ph[2]});
            case (ph % 4)
                0: begin sender_pct = 0;  stall_pct = 0;  end
                1: begin sender_pct = 67; stall_pct = 0;  end
                2: begin sender_pct = 0;  stall_pct = 67; end
                default: begin sender_pct = 24; stall_pct = 24; end
            endcase

            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // Well-formed song: header, body words, start, ticks.
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            put_req(OP_WRITE, 14'd0, 16'h0000, 1'b0, 1'b0, 16'h0000);
                            put_req(OP_WRITE, 14'd1, 16'h0000, 1'b0, 1'b0, 16'h0000);
                        end
                        1, 2:
                        begin
                            head = {8'($urandom),
                                    ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00};
                            put_req(OP_WRITE, 14'd0, head, 1'b0, 1'b0, 16'h0000);
                        end
                        default:
                        begin
                        end
                    endcase
                    n = $urandom_range(0, 6);
                    repeat (n)
                        put_req(OP_WRITE, 14'($urandom_range(1, 63)),
                                ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                                16'($urandom_range(0, 511)), 1'b0, 1'b0, 16'h0000);
                    if ($urandom_range(0, 7) == 0)
                        await_drain();
                    put_req(OP_START, 14'($urandom), 16'($urandom), 1'b0, 1'b0, 16'h0000);
                    n = $urandom_range(4, 40);
                    repeat (n)
                        put_tick();
                end
                else
                begin
                    // Single stray request.
                    case ($urandom_range(0, 3))
                        0: put_req(OP_UNUSED, 14'($urandom), 16'($urandom),
                                   1'b0, 1'b0, 16'h0000);
                        1: put_tick();
                        2: put_req(OP_WRITE, 14'($urandom), 16'($urandom),
                                   1'b0, 1'b0, 16'h0000);
                        default: put_req(OP_START, 14'($urandom), 16'($urandom),
                                         1'b0, 1'b0, 16'h0000);
                    endcase
                end
            end
        end

        await_drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: imf_music_sequencer.f
src/imfs_pkg.sv
src/imfs_song_mem.sv
src/imf_music_sequencer.sv
src/imfs_checker.sv
test/tb.sv
